/* design/pbacd_pkg.sv */
// Package with shared types and constants for the block-average change detector.
package pbacd_pkg;

    // Field widths fixed by the interface.
    localparam int CH_W    = 3;
    localparam int SMP_W   = 16;
    localparam int SUM_W   = 24;
    localparam int CNT_W   = 8;
    localparam int THR_W   = 16;
    localparam int PCT_W   = 15;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // Width of the zero-extended channel index, enough to compare with up to 63 channels.
    localparam int CH_EXT_W = 6;

    // Full-scale percent in Q8 (100 * 256).
    localparam logic [PCT_W-1:0] PERCENT_FULL = 15'd25600;
    localparam logic [SMP_W-1:0] RAW_MAX      = 16'hFFFF;
    localparam logic [SUM_W-1:0] SUM_MAX      = 24'hFFFFFF;

    // Register reset values.
    localparam logic [CNT_W-1:0] AVG_COUNT_RESET = 8'd10;
    localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd655;

    // Register indexes, taken from paddr[2].
    localparam logic REG_AVG_COUNT = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;

    // One state memory entry: the last reported average and the running sum.
    typedef struct packed {
        logic [SMP_W-1:0] last;
        logic [SUM_W-1:0] sum;
    } entry_t;

    // Request to the shared divider.
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

endpackage

/* design/pot_block_average_change_detect_top.sv */
// Top level of the potentiometer block-average change detector.
// Samples are taken one channel per request in scan order; the highest channel ends a scan.
// A sample in an ordinary scan is accepted, then the channel's entry in the state memory gets a
// read-modify-write. In the last scan of a block each sample passes through the accept, the
// memory read, 24 steps of the shared radix-2 divider that forms sum / average_count and the
// taking of its quotient, then the percent product and the percent correction with write-back
// and hand-off to the output.
// A result waits in the output register; the next sample is accepted meanwhile and only the
// write-back of a new report waits until that register is free. Per-channel state is cleared
// at reset through valid bits, so no clearing pass is needed. Registers: average_count at
// byte address 0 (0 acts as 1), change_threshold at byte address 4.
module pot_block_average_change_detect_top #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Sample channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [pbacd_pkg::CH_W-1:0]     s_channel,
    input  logic [pbacd_pkg::SMP_W-1:0]    s_sample,
    // Report channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [pbacd_pkg::CH_W-1:0]     m_pot_index,
    output logic [pbacd_pkg::SMP_W-1:0]    m_average_raw,
    output logic [pbacd_pkg::PCT_W-1:0]    m_percent_q8,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pbacd_pkg::APB_AW-1:0]   paddr,
    input  logic [pbacd_pkg::APB_DW-1:0]   pwdata,
    output logic [pbacd_pkg::APB_DW-1:0]   prdata,
    output logic                           pready
);
    import pbacd_pkg::*;

    localparam int AW      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PROD_W  = SMP_W + PCT_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_PCT  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]         state_reg, state_next;

    logic [CNT_W-1:0]   avg_count_reg;
    logic [THR_W-1:0]   threshold_reg;
    logic [CNT_W-1:0]   scan_count_reg;

    logic [CH_W-1:0]    ch_reg;
    logic [SMP_W-1:0]   sample_reg;
    logic               last_scan_reg;
    logic [CNT_W-1:0]   divisor_reg;
    logic [SMP_W-1:0]   prev_reg;
    logic [SMP_W-1:0]   avg_reg;
    logic               report_reg;
    logic [PROD_W-1:0]  prod_reg;

    logic               m_valid_reg;
    logic [CH_W-1:0]    m_pot_index_reg;
    logic [SMP_W-1:0]   m_average_raw_reg;
    logic [PCT_W-1:0]   m_percent_q8_reg;

    logic               in_accept;
    logic [CH_EXT_W-1:0] in_ch_ext;
    logic [CH_EXT_W-1:0] cur_ch_ext;
    logic               in_range;
    logic               cur_is_last;
    logic [CNT_W-1:0]   eff_count;
    logic               in_last_scan;
    logic               cfg_write;

    entry_t             rd_entry;
    logic               wr_en;
    entry_t             wr_entry;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_sat;

    div_req_t           div_req;
    logic               div_done;
    logic [SUM_W-1:0]   quotient;
    logic [SMP_W-1:0]   avg_sat;
    logic [SMP_W-1:0]   abs_diff;

    logic [PCT_W-1:0]   pct_est;
    logic [SMP_W:0]     pct_rem;
    logic [PCT_W-1:0]   pct_value;
    logic               out_free;
    logic               out_load;
    logic               writeback;

    // Request decode and scan position.
    always_comb begin
        in_accept    = s_valid && s_ready;
        in_ch_ext    = CH_EXT_W'(s_channel);
        cur_ch_ext   = CH_EXT_W'(ch_reg);
        in_range     = in_ch_ext < CH_EXT_W'(NUM_CHANNELS);
        cur_is_last  = cur_ch_ext == CH_EXT_W'(NUM_CHANNELS - 1);
        eff_count    = (avg_count_reg == '0) ? CNT_W'(1) : avg_count_reg;
        in_last_scan = ({1'b0, scan_count_reg} + 9'd1) >= {1'b0, eff_count};
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Configuration registers.
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_count_reg <= AVG_COUNT_RESET;
            threshold_reg <= THRESHOLD_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_AVG_COUNT: avg_count_reg <= pwdata[CNT_W-1:0];
                REG_THRESHOLD: threshold_reg <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_AVG_COUNT: prdata = APB_DW'(avg_count_reg);
            REG_THRESHOLD: prdata = APB_DW'(threshold_reg);
            default:       prdata = '0;
        endcase
    end

    // Per-channel state memory.
    pbacd_state_mem #(
        .DEPTH (NUM_CHANNELS),
        .AW    (AW)
    ) u_state_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (in_accept && in_range),
        .rd_addr (in_ch_ext[AW-1:0]),
        .rd_data (rd_entry),
        .wr_en   (wr_en),
        .wr_addr (cur_ch_ext[AW-1:0]),
        .wr_data (wr_entry)
    );

    // Saturating sum update on the entry just read.
    always_comb begin
        sum_wide = {1'b0, rd_entry.sum} + (SUM_W + 1)'(sample_reg);
        sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    end

    // Shared divider forms the block average.
    always_comb begin
        div_req.start    = (state_reg == ST_READ) && last_scan_reg;
        div_req.dividend = sum_sat;
        div_req.divisor  = divisor_reg;
    end

    pbacd_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (quotient)
    );

    // Average saturation and deadband comparison.
    always_comb begin
        avg_sat  = (quotient[SUM_W-1:SMP_W] != '0) ? RAW_MAX : quotient[SMP_W-1:0];
        abs_diff = (avg_sat > prev_reg) ? (avg_sat - prev_reg) : (prev_reg - avg_sat);
    end

    // Percent: product / 65535 as product >> 16 plus one correction step.
    always_comb begin
        pct_est   = prod_reg[PROD_W-1:SMP_W];
        pct_rem   = {1'b0, prod_reg[SMP_W-1:0]} + (SMP_W + 1)'(pct_est);
        pct_value = pct_est + PCT_W'(pct_rem >= {1'b0, RAW_MAX});
    end

    // Write-back and output hand-off.
    always_comb begin
        out_free  = !m_valid_reg || m_ready;
        writeback = (state_reg == ST_OUT) && (!report_reg || out_free);
        out_load  = writeback && report_reg;
        wr_en     = ((state_reg == ST_READ) && !last_scan_reg) || writeback;
        if (state_reg == ST_READ) begin
            wr_entry.last = rd_entry.last;
            wr_entry.sum  = sum_sat;
        end else begin
            wr_entry.last = report_reg ? avg_reg : prev_reg;
            wr_entry.sum  = '0;
        end
    end

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_accept && in_range) state_next = ST_READ;
            ST_READ: state_next = last_scan_reg ? ST_DIV : ST_IDLE;
            ST_DIV:  if (div_done) state_next = ST_PCT;
            ST_PCT:  state_next = ST_OUT;
            ST_OUT:  if (writeback) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers: state and scan counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            scan_count_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (((state_reg == ST_READ) && !last_scan_reg) && cur_is_last) begin
                scan_count_reg <= scan_count_reg + 1'b1;
            end else if (writeback && cur_is_last) begin
                scan_count_reg <= '0;
            end
        end
    end

    // Item payload registers.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            ch_reg        <= s_channel;
            sample_reg    <= s_sample;
            last_scan_reg <= in_last_scan;
            divisor_reg   <= eff_count;
        end
        if (state_reg == ST_READ) begin
            prev_reg <= rd_entry.last;
        end
        if ((state_reg == ST_DIV) && div_done) begin
            avg_reg    <= avg_sat;
            report_reg <= abs_diff > threshold_reg;
        end
        if (state_reg == ST_PCT) begin
            prod_reg <= PROD_W'(avg_reg) * PROD_W'(PERCENT_FULL);
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_pot_index_reg   <= ch_reg;
            m_average_raw_reg <= avg_reg;
            m_percent_q8_reg  <= pct_value;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pot_index   = m_pot_index_reg;
    assign m_average_raw = m_average_raw_reg;
    assign m_percent_q8  = m_percent_q8_reg;

`ifndef SYNTHESIS
    // The divider finishes only while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    // A memory write never coincides with a new request being taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !in_accept)
        else $error("state memory written while a request is accepted");

    // A loaded result never overwrites one that is still waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && m_valid_reg) |-> m_ready)
        else $error("pending report overwritten");

    // After a report the output register holds a valid result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid_reg)
        else $error("report loaded but not presented");
`endif

endmodule

/* design/pbacd_state_mem.sv */
// Per-channel state memory with registered read and reset-cleared valid bits.
module pbacd_state_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output pbacd_pkg::entry_t     rd_data,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  pbacd_pkg::entry_t     wr_data
);
    import pbacd_pkg::*;

    entry_t             entry_mem_reg [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    entry_t             rd_data_reg;
    logic               rd_valid_reg;

    // Storage array: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= entry_mem_reg[rd_addr];
        end
    end

    // Valid bits: an entry never written reads as all zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* design/pbacd_divider.sv */
// Radix-2 restoring divider of a channel sum by the block's average count, one quotient bit per cycle.
module pbacd_divider (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pbacd_pkg::div_req_t            req,
    output logic                           done,
    output logic [pbacd_pkg::SUM_W-1:0]    quotient
);
    import pbacd_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic               busy_reg;
    logic               done_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [SUM_W-1:0]   quo_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   div_reg;

    logic [CNT_W:0]     shifted;
    logic               fits;
    logic [CNT_W:0]     diff;

    // One restoring step: shift in the next dividend bit and try the subtraction.
    always_comb begin
        shifted = {rem_reg, quo_reg[SUM_W-1]};
        fits    = shifted >= {1'b0, div_reg};
        diff    = shifted - {1'b0, div_reg};
    end

    // Control: busy until every dividend bit has been stepped through, then a one-cycle done pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits shift in where the dividend bits shift out.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            div_reg <= req.divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            rem_reg <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* sim/pot_block_average_change_detect_top_test.sv */
// Self-checking testbench for the potentiometer block-average change detector.
`timescale 1ns / 1ps

module pot_block_average_change_detect_top_test;
    import pbacd_pkg::*;

    localparam int NUM_CH = 8;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CH - 1);
    localparam int unsigned TOTAL_ITEMS = 1625;
    localparam int unsigned SETTLE_CYCLES = 80;
    localparam int unsigned DRAIN_LIMIT = 20000;
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned MAX_PRINTED = 200;

    // One change report as the block should present it.
    typedef struct packed {
        logic [CH_W-1:0]  pot;
        logic [SMP_W-1:0] avg;
        logic [PCT_W-1:0] pct;
    } pot_report_t;

    // Tracks the per-channel sums and last averages and keeps the reports still owed.
    class pot_change_scoreboard;
        logic [CNT_W-1:0] avg_count;
        logic [THR_W-1:0] threshold;
        logic [SUM_W-1:0] chan_sum [NUM_CH];
        logic [SMP_W-1:0] last_avg [NUM_CH];
        logic [CNT_W-1:0] scans_done;
        pot_report_t      reports_due [$];
        int unsigned      errors;

        function new();
            avg_count  = AVG_COUNT_RESET;
            threshold  = THRESHOLD_RESET;
            scans_done = '0;
            errors     = 0;
            foreach (chan_sum[i]) begin
                chan_sum[i] = '0;
                last_avg[i] = '0;
            end
        endfunction

        function void set_reg(input logic idx, input logic [APB_DW-1:0] value);
            if (idx == REG_AVG_COUNT) begin
                avg_count = value[CNT_W-1:0];
            end else begin
                threshold = value[THR_W-1:0];
            end
        endfunction

        // Accumulate one accepted sample and queue the report it causes, if any.
        function void take_sample(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] smp);
            int unsigned divisor;
            int unsigned total;
            int unsigned avg_val;
            int unsigned prev;
            int unsigned gap;
            int unsigned pct_val;
            bit          closing;
            pot_report_t rep;
            divisor = (avg_count == '0) ? 1 : 32'(avg_count);
            closing = (32'(scans_done) + 32'd1) >= divisor;
            total = chan_sum[ch] + smp;
            if (total > 32'(SUM_MAX)) begin
                total = 32'(SUM_MAX);
            end
            chan_sum[ch] = total[SUM_W-1:0];
            if (closing) begin
                avg_val = total / divisor;
                if (avg_val > 32'(RAW_MAX)) begin
                    avg_val = 32'(RAW_MAX);
                end
                prev = 32'(last_avg[ch]);
                gap  = (avg_val > prev) ? avg_val - prev : prev - avg_val;
                if (gap > 32'(threshold)) begin
                    pct_val  = (avg_val * 32'(PERCENT_FULL)) / 32'(RAW_MAX);
                    rep.pot  = ch;
                    rep.avg  = avg_val[SMP_W-1:0];
                    rep.pct  = pct_val[PCT_W-1:0];
                    reports_due.push_back(rep);
                    last_avg[ch] = avg_val[SMP_W-1:0];
                end
                chan_sum[ch] = '0;
            end
            // The highest channel ends a scan.
            if (ch == LAST_CH) begin
                scans_done = closing ? '0 : scans_done + 1'b1;
            end
        endfunction

        task flag_mismatch(input string what);
            if (errors < MAX_PRINTED) begin
                $display("%0t mismatch: %s", $realtime, what);
            end
            errors++;
        endtask

        // Compare one accepted report with the oldest one owed.
        task check_report(input logic [CH_W-1:0] pot, input logic [SMP_W-1:0] avg,
                          input logic [PCT_W-1:0] pct);
            pot_report_t want;
            if (reports_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected report pot %0d avg %0d pct %0d",
                                        pot, avg, pct));
                return;
            end
            want = reports_due.pop_front();
            if (pot !== want.pot) begin
                flag_mismatch($sformatf("pot_index %0d, wanted %0d", pot, want.pot));
            end
            if (avg !== want.avg) begin
                flag_mismatch($sformatf("average_raw %0d, wanted %0d (pot %0d)",
                                        avg, want.avg, want.pot));
            end
            if (pct !== want.pct) begin
                flag_mismatch($sformatf("percent_q8 %0d, wanted %0d (pot %0d)",
                                        pct, want.pct, want.pot));
            end
        endtask
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [CH_W-1:0]    s_channel;
    logic [SMP_W-1:0]   s_sample;
    logic               m_valid;
    logic               m_ready;
    logic [CH_W-1:0]    m_pot_index;
    logic [SMP_W-1:0]   m_average_raw;
    logic [PCT_W-1:0]   m_percent_q8;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    pot_change_scoreboard sb;

    bit              tx_idle_on = 1'b1;
    bit              rx_idle_on = 1'b1;
    int unsigned     hold_req = 0;
    int unsigned     hold_len = 0;
    int unsigned     items_sent = 0;
    int unsigned     cycle_count = 0;
    logic [CH_W-1:0] scan_pos = '0;
    int              pot_level [NUM_CH] = '{NUM_CH{32768}};

    pot_block_average_change_detect_top #(
        .NUM_CHANNELS(NUM_CH)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_channel     (s_channel),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pot_index   (m_pot_index),
        .m_average_raw (m_average_raw),
        .m_percent_q8  (m_percent_q8),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Run limit: ends the simulation if the regression hangs.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Observe both channels at the clock edge where each request is taken.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_report(m_pot_index, m_average_raw, m_percent_q8);
            end
            if (s_valid && s_ready) begin
                sb.take_sample(s_channel, s_sample);
            end
        end
    end

    // Report sink: random back-pressure, plus long hold-offs on request from the stimulus.
    initial begin : report_sink
        int unsigned hold_left;
        int unsigned hold_seen;
        hold_left = 0;
        hold_seen = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = hold_len;
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= !(rx_idle_on && $urandom_range(99) < 22);
            end
        end
    end

    // One register write: setup cycle, then access cycle.
    task automatic write_reg(input logic idx, input logic [APB_DW-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_reg(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write both registers; the bits above each register's width sometimes carry junk.
    task automatic apply_config(input int unsigned count_val, input int unsigned thr_val);
        logic [APB_DW-1:0] junk;
        junk = $urandom_range(1) ? $urandom : '0;
        write_reg(REG_AVG_COUNT, (junk & 32'hFFFF_FF00) | (count_val & 32'h0000_00FF));
        junk = $urandom_range(1) ? $urandom : '0;
        write_reg(REG_THRESHOLD, (junk & 32'hFFFF_0000) | (thr_val & 32'h0000_FFFF));
    endtask

    // Present one sample request and hold it until it is taken.
    task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] smp);
        if (tx_idle_on && $urandom_range(99) < 22) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(3)) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_channel <= ch;
        s_sample  <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Let the block go idle: all reports in, then time for a sample still in the divider.
    task automatic settle();
        int unsigned waited;
        stop_sending();
        waited = 0;
        while (sb.reports_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_scan(input logic [SMP_W-1:0] vals [NUM_CH]);
        for (int i = 0; i < NUM_CH; i++) begin
            send_sample(CH_W'(i), vals[i]);
        end
    endtask

    // Samples mostly wander around a per-channel level so that thresholds matter.
    function automatic logic [SMP_W-1:0] pick_sample(input logic [CH_W-1:0] ch);
        int level;
        case ($urandom_range(19))
            0: return '0;
            1: return RAW_MAX;
            2: return SMP_W'($urandom);
            default: begin
                if ($urandom_range(9) == 0) begin
                    pot_level[ch] = $urandom_range(65535);
                end
                level = pot_level[ch] + int'($urandom_range(1200)) - 600;
                if (level < 0) begin
                    level = 0;
                end
                if (level > 65535) begin
                    level = 65535;
                end
                return SMP_W'(level);
            end
        endcase
    endfunction

    // Scan-ordered samples; a few percent jump to a random channel and break the order.
    task automatic run_scan_burst(input int unsigned n, input int unsigned noise_pct);
        logic [CH_W-1:0] ch;
        for (int unsigned k = 0; k < n; k++) begin
            if ($urandom_range(99) < noise_pct) begin
                ch = CH_W'($urandom);
            end else begin
                ch = scan_pos;
                scan_pos = scan_pos + 1'b1;
            end
            send_sample(ch, pick_sample(ch));
        end
    endtask

    task automatic pick_config();
        int unsigned count_val;
        int unsigned thr_val;
        case ($urandom_range(7))
            0: count_val = 0;
            1, 2: count_val = 1;
            3: count_val = 2;
            4: count_val = 3;
            5: count_val = $urandom_range(4, 8);
            6: count_val = $urandom_range(9, 16);
            default: count_val = $urandom_range(1) ? 255 : $urandom_range(2, 6);
        endcase
        case ($urandom_range(7))
            0: thr_val = 0;
            1: thr_val = 655;
            2: thr_val = 65535;
            3: thr_val = $urandom_range(65535);
            default: thr_val = $urandom_range(2500);
        endcase
        apply_config(count_val, thr_val);
    endtask

    initial begin : stimulus
        logic [SMP_W-1:0] scan_vals [NUM_CH];
        int unsigned      phase;
        sb = new();
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_channel = '0;
        s_sample  = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Every sample closes a block; zero threshold reports any change at all.
        apply_config(1, 0);
        scan_vals = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE,
                      16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA};
        send_scan(scan_vals);
        settle();

        // Zero count acts as one; only a full-scale swing beats this threshold.
        apply_config(0, 65534);
        scan_vals = '{16'hFFFF, 16'h0000, 16'h0000, 16'h0001,
                      16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555};
        send_scan(scan_vals);
        settle();

        // Largest count and threshold: the samples only accumulate.
        apply_config(255, 65535);
        scan_vals = '{16'h1234, 16'hFFFF, 16'h0000, 16'hC3A5,
                      16'h0F0F, 16'hF0F0, 16'hFFFF, 16'h0000};
        send_scan(scan_vals);
        settle();

        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            tx_idle_on = 1'b1;
            rx_idle_on = 1'b1;
            case (phase)
                0: begin
                    // Five scans at count six, then the count drops below the scan counter.
                    apply_config(1, $urandom_range(2500));
                    send_sample(LAST_CH, pick_sample(LAST_CH));
                    settle();
                    apply_config(6, $urandom_range(2500));
                    scan_pos = '0;
                    run_scan_burst(40, 0);
                    settle();
                    apply_config(2, $urandom_range(2500));
                    scan_pos = '0;
                    run_scan_burst(24, 0);
                end
                1: begin
                    // One channel repeats at full scale until its sum saturates.
                    apply_config(1, 0);
                    send_sample(LAST_CH, pick_sample(LAST_CH));
                    settle();
                    apply_config(2, 0);
                    repeat (260) send_sample('0, RAW_MAX);
                    scan_pos = '0;
                    run_scan_burst(16, 0);
                end
                2: begin
                    // Reports on every change while the sink holds off: the block must stall.
                    apply_config(1, 0);
                    hold_len = 400;
                    hold_req++;
                    run_scan_burst(120, 8);
                end
                3: begin
                    // Long stretch at full rate on both sides.
                    tx_idle_on = 1'b0;
                    rx_idle_on = 1'b0;
                    pick_config();
                    run_scan_burst(250, 8);
                end
                default: begin
                    pick_config();
                    run_scan_burst($urandom_range(16, 160), 8);
                end
            endcase
            settle();
            phase++;
        end

        if (sb.reports_due.size() != 0) begin
            sb.flag_mismatch($sformatf("%0d reports never arrived", sb.reports_due.size()));
        end
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* sim.f */
design/pbacd_pkg.sv
design/pbacd_state_mem.sv
design/pbacd_divider.sv
design/pot_block_average_change_detect_top.sv
sim/pot_block_average_change_detect_top_test.sv
